@@ src/twmb_pkg.sv @@
package twmb_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned CAP_W      = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 8'd1;

  // Register reset values
  localparam logic [WIN_W-1:0] WINDOW_RST = 32'd5000000;
  localparam logic [CAP_W-1:0] CAP_RST    = 8'd100;

  // Command codes
  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // One queued command, front to back
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] time_us;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  // One result, back to ports
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] time_us;
    logic [TAG_W-1:0]  tag;
  } res_t;

endpackage

@@ src/timestamp_window_match_buffer.sv @@
// Push: queued at accept and written to the ring when the engine takes it, then
//   oldest entries are dropped while over capacity or while the span exceeds the window; no result beat.
// Lookup: done_o answers a miss on an empty buffer, the newest entry when time_us is zero,
//   else the nearest of the N stored entries after a search (one ring read per cycle).
// One command runs at a time; a two-command queue takes beats meanwhile, busy when full.
// Reset clears the queue, the ring pointers and the registers; storage is left as is.
module timestamp_window_match_buffer #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [twmb_pkg::TIME_W-1:0]        time_us_i,
  input  logic [twmb_pkg::TAG_W-1:0]         payload_tag_i,
  input  logic                               payload_empty_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [twmb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [twmb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic                               match_valid_o,
  output logic [twmb_pkg::TIME_W-1:0]        match_time_us_o,
  output logic [twmb_pkg::TAG_W-1:0]         match_tag_o
);

  logic [twmb_pkg::WIN_W-1:0] window_q, window_d;
  logic [twmb_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                       cmd_valid;
  twmb_pkg::cmd_t             cmd;
  logic                       cmd_pop;
  twmb_pkg::res_t             res;

  // Decode configuration beats
  assign cfg_ready_o = 1'b1;

  always_comb begin
    window_d = window_q;
    cap_d    = cap_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        twmb_pkg::REG_TIME_WINDOW: window_d = cfg_data_i[twmb_pkg::WIN_W-1:0];
        twmb_pkg::REG_CAPACITY:    cap_d    = cfg_data_i[twmb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= twmb_pkg::WINDOW_RST;
      cap_q    <= twmb_pkg::CAP_RST;
    end else begin
      window_q <= window_d;
      cap_q    <= cap_d;
    end
  end

  twmb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .time_us_i       (time_us_i),
    .payload_tag_i   (payload_tag_i),
    .payload_empty_i (payload_empty_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  twmb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .window_i     (window_q),
    .capacity_i   (cap_q),
    .res_strobe_o (done_o),
    .res_o        (res)
  );

  assign match_valid_o   = res.valid;
  assign match_time_us_o = res.time_us;
  assign match_tag_o     = res.tag;

endmodule

@@ src/twmb_ram.sv @@
module twmb_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/twmb_front.sv @@
module twmb_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation_i,
  input  logic [twmb_pkg::TIME_W-1:0]      time_us_i,
  input  logic [twmb_pkg::TAG_W-1:0]       payload_tag_i,
  input  logic                             payload_empty_i,
  output logic                             cmd_valid_o,
  output twmb_pkg::cmd_t                   cmd_o,
  input  logic                             cmd_pop_i
);

  twmb_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           accept;
  logic           keep;
  twmb_pkg::cmd_t cmd_new;

  // Accept a beat; drop pushes without data here
  assign accept = start && !busy;
  assign keep   = accept && !((twmb_pkg::op_e'(operation_i) == twmb_pkg::OP_PUSH)
                              && payload_empty_i);

  always_comb begin
    cmd_new.op      = twmb_pkg::op_e'(operation_i);
    cmd_new.time_us = time_us_i;
    cmd_new.tag     = payload_tag_i;
  end

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = keep ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, keep} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (keep) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign busy        = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

endmodule

@@ src/twmb_back.sv @@
module twmb_back #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  twmb_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic [twmb_pkg::WIN_W-1:0]    window_i,
  input  logic [twmb_pkg::CAP_W-1:0]    capacity_i,
  output logic                          res_strobe_o,
  output twmb_pkg::res_t                res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > twmb_pkg::CAP_W) ? CW : twmb_pkg::CAP_W;
  localparam int unsigned TW = twmb_pkg::TIME_W;
  localparam int unsigned GW = twmb_pkg::TAG_W;
  localparam int unsigned EW = TW + GW;

  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_TRIM_CHK = 5'b00010,
    S_TRIM_CMP = 5'b00100,
    S_NEWEST   = 5'b01000,
    S_SCAN     = 5'b10000
  } state_e;

  // Ring slot of base plus offset, both below DEPTH
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            rd_pend_q, rd_pend_d;
  logic            d1_vld_q, d1_vld_d;
  logic            first_q, first_d;
  logic            res_strobe_q, res_strobe_d;

  logic [TW-1:0]   new_time_q, new_time_d;
  logic [TW-1:0]   ref_q, ref_d;
  logic [TW-1:0]   d1_diff_q, d1_diff_d;
  logic [TW-1:0]   d1_time_q, d1_time_d;
  logic [GW-1:0]   d1_tag_q, d1_tag_d;
  logic [TW-1:0]   best_diff_q, best_diff_d;
  logic [TW-1:0]   best_time_q, best_time_d;
  logic [GW-1:0]   best_tag_q, best_tag_d;
  twmb_pkg::res_t  res_q, res_d;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [EW-1:0]   rd_data;
  logic [TW-1:0]   rd_time;
  logic [GW-1:0]   rd_tag;

  logic [MW-1:0]   cap_ext;
  logic [MW-1:0]   cap_sat;
  logic [CW-1:0]   cap_eff;
  logic [AW-1:0]   head_inc;
  logic [CW-1:0]   count_m1;
  logic [TW:0]     span;
  logic            span_exceeds;

  twmb_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_time = rd_data[EW-1:GW];
  assign rd_tag  = rd_data[GW-1:0];

  // Clamp capacity to 1..DEPTH
  always_comb begin
    cap_ext = MW'(capacity_i);
    if (cap_ext == '0) begin
      cap_sat = MW'(1);
    end else if (cap_ext > DEPTH_M) begin
      cap_sat = DEPTH_M;
    end else begin
      cap_sat = cap_ext;
    end
    cap_eff = cap_sat[CW-1:0];
  end

  assign head_inc = (head_q == LAST_A) ? '0 : head_q + 1'b1;
  assign count_m1 = count_q - 1'b1;

  // Signed span newest minus oldest against the window
  assign span         = {1'b0, new_time_q} - {1'b0, rd_time};
  assign span_exceeds = !span[TW] && (span[TW-1:0] > TW'(window_i));

  // Distance stage of the scan
  always_comb begin
    d1_vld_d  = rd_pend_q;
    d1_time_d = rd_time;
    d1_tag_d  = rd_tag;
    if (rd_time > ref_q) begin
      d1_diff_d = rd_time - ref_q;
    end else begin
      d1_diff_d = ref_q - rd_time;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    first_d      = first_q;
    res_strobe_d = 1'b0;
    new_time_d   = new_time_q;
    ref_d        = ref_q;
    best_diff_d  = best_diff_q;
    best_time_d  = best_time_q;
    best_tag_d   = best_tag_q;
    res_d        = res_q;
    cmd_pop_o    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    wr_data      = {cmd_i.time_us, cmd_i.tag};
    rd_en        = 1'b0;
    rd_addr      = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == twmb_pkg::OP_PUSH) begin
            // append; a full ring overwrites its oldest slot
            wr_en      = 1'b1;
            new_time_d = cmd_i.time_us;
            if (count_q == DEPTH_C) begin
              wr_addr = head_q;
              head_d  = head_inc;
            end else begin
              wr_addr = slot_add(head_q, count_q[AW-1:0]);
              count_d = count_q + 1'b1;
            end
            state_d = S_TRIM_CHK;
          end else if (count_q == '0) begin
            res_strobe_d = 1'b1;
            res_d        = '0;
          end else if (cmd_i.time_us == '0) begin
            rd_en   = 1'b1;
            rd_addr = slot_add(head_q, count_m1[AW-1:0]);
            state_d = S_NEWEST;
          end else begin
            ref_d   = cmd_i.time_us;
            idx_d   = '0;
            first_d = 1'b1;
            state_d = S_SCAN;
          end
        end
      end

      S_TRIM_CHK: begin
        if (count_q > cap_eff) begin
          head_d  = head_inc;
          count_d = count_m1;
        end else if (count_q <= CW'(1)) begin
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = S_TRIM_CMP;
        end
      end

      S_TRIM_CMP: begin
        // drop the oldest while the span is too wide, else finish
        if (span_exceeds) begin
          head_d  = head_inc;
          count_d = count_m1;
          state_d = S_TRIM_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_NEWEST: begin
        res_strobe_d  = 1'b1;
        res_d.valid   = 1'b1;
        res_d.time_us = rd_time;
        res_d.tag     = rd_tag;
        state_d       = S_IDLE;
      end

      S_SCAN: begin
        // issue one read per cycle, oldest first
        if (idx_q < count_q) begin
          rd_en     = 1'b1;
          rd_addr   = slot_add(head_q, idx_q[AW-1:0]);
          idx_d     = idx_q + 1'b1;
          rd_pend_d = 1'b1;
        end
        // keep strictly nearer entries so the oldest wins ties
        if (d1_vld_q) begin
          if (first_q || (d1_diff_q < best_diff_q)) begin
            best_diff_d = d1_diff_q;
            best_time_d = d1_time_q;
            best_tag_d  = d1_tag_q;
          end
          first_d = 1'b0;
        end
        if ((idx_q == count_q) && !rd_pend_q && !d1_vld_q) begin
          res_strobe_d  = 1'b1;
          res_d.valid   = 1'b1;
          res_d.time_us = best_time_q;
          res_d.tag     = best_tag_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      d1_vld_q     <= 1'b0;
      first_q      <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      rd_pend_q    <= rd_pend_d;
      d1_vld_q     <= d1_vld_d;
      first_q      <= first_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  // Data path registers
  always_ff @(posedge clk_i) begin
    new_time_q  <= new_time_d;
    ref_q       <= ref_d;
    d1_diff_q   <= d1_diff_d;
    d1_time_q   <= d1_time_d;
    d1_tag_q    <= d1_tag_d;
    best_diff_q <= best_diff_d;
    best_time_q <= best_time_d;
    best_tag_q  <= best_tag_d;
    res_q       <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

@@ src/twmb_checker.sv @@
module twmb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            operation_i,
  input logic                            done_o,
  input logic                            match_valid_o,
  input logic [twmb_pkg::TIME_W-1:0]     match_time_us_o,
  input logic [twmb_pkg::TAG_W-1:0]      match_tag_o
);

  logic [2:0] pend_q, pend_d;
  logic       lookup_beat;

  // Track lookups accepted but not yet answered
  assign lookup_beat = start && !busy
                       && (twmb_pkg::op_e'(operation_i) == twmb_pkg::OP_LOOKUP);

  always_comb begin
    pend_d = pend_q + {2'b00, lookup_beat} - {2'b00, done_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Reset leaves the ports quiet on the next edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> (!done_o && !busy))
    else $error("done_o or busy high after reset");

  // A miss carries zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !match_valid_o) |-> ((match_time_us_o == '0) && (match_tag_o == '0)))
    else $error("miss result with nonzero fields");

  // Every result answers an earlier lookup
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pend_q != 3'd0))
    else $error("result without an open lookup");

  // Queue plus engine bound the lookups in flight
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many lookups in flight");

endmodule

bind timestamp_window_match_buffer twmb_checker u_twmb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .operation_i     (operation_i),
  .done_o          (done_o),
  .match_valid_o   (match_valid_o),
  .match_time_us_o (match_time_us_o),
  .match_tag_o     (match_tag_o)
);
